### design/ordered_sequence_store_defines.svh
// Assertion macros used by the top-level design file.
`ifndef ORDERED_SEQUENCE_STORE_DEFINES_SVH
`define ORDERED_SEQUENCE_STORE_DEFINES_SVH
`ifndef SYNTHESIS
`define OSS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define OSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OSS_ASSERT(lbl, clk, rst_n, prop)
`define OSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/oss_pkg.sv
`default_nettype none
package oss_pkg;

    localparam int DEFAULT_CAPACITY = 32;

    localparam logic [3:0] OP_APPEND     = 4'd0;
    localparam logic [3:0] OP_REMOVE     = 4'd1;
    localparam logic [3:0] OP_INS_AFTER  = 4'd2;
    localparam logic [3:0] OP_INS_BEFORE = 4'd3;
    localparam logic [3:0] OP_READ       = 4'd4;
    localparam logic [3:0] OP_FIND_ALL   = 4'd5;
    localparam logic [3:0] OP_BSEARCH    = 4'd6;
    localparam logic [3:0] OP_SORT       = 4'd7;
    localparam logic [3:0] OP_DUMP       = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // datapath micro-operations
    localparam logic [4:0] UOP_NOP       = 5'd0;
    localparam logic [4:0] UOP_LOAD      = 5'd1;
    localparam logic [4:0] UOP_EMIT_CODE = 5'd2;
    localparam logic [4:0] UOP_APPEND    = 5'd3;
    localparam logic [4:0] UOP_SCAN_RD   = 5'd4;
    localparam logic [4:0] UOP_SCAN_CHK  = 5'd5;
    localparam logic [4:0] UOP_FA_END    = 5'd6;
    localparam logic [4:0] UOP_RM_RD     = 5'd7;
    localparam logic [4:0] UOP_RM_WR     = 5'd8;
    localparam logic [4:0] UOP_RM_DONE   = 5'd9;
    localparam logic [4:0] UOP_INS_INIT  = 5'd10;
    localparam logic [4:0] UOP_INS_RD    = 5'd11;
    localparam logic [4:0] UOP_INS_WR    = 5'd12;
    localparam logic [4:0] UOP_INS_DONE  = 5'd13;
    localparam logic [4:0] UOP_READ_PIN  = 5'd14;
    localparam logic [4:0] UOP_EMIT_READ = 5'd15;
    localparam logic [4:0] UOP_BS_INIT   = 5'd16;
    localparam logic [4:0] UOP_BS_RD     = 5'd17;
    localparam logic [4:0] UOP_BS_CHK    = 5'd18;
    localparam logic [4:0] UOP_SORT_INIT = 5'd19;
    localparam logic [4:0] UOP_SORT_LD   = 5'd20;
    localparam logic [4:0] UOP_SORT_CMP  = 5'd21;
    localparam logic [4:0] UOP_SORT_END  = 5'd22;
    localparam logic [4:0] UOP_DUMP_RD   = 5'd23;
    localparam logic [4:0] UOP_DUMP_EMIT = 5'd24;

    typedef struct packed {
        logic [4:0] uop;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [3:0] op;
        logic       full;
        logic       empty;
        logic       cnt_ge2;
        logic       pin_ok;
        logic       scan_done;
        logic       match;
        logic       pend;
        logic       ins_more;
        logic       bs_done;
        logic       sort_last;
        logic       lim_one;
        logic       dump_last;
    } stat_t;

endpackage
`default_nettype wire

### design/oss_control.sv
`default_nettype none
module oss_control (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire oss_pkg::stat_t stat,
    output oss_pkg::cmd_t      cmd,
    output logic               busy
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_SCAN_RD  = 5'd2;
    localparam logic [4:0] S_SCAN_CHK = 5'd3;
    localparam logic [4:0] S_RM_RD    = 5'd4;
    localparam logic [4:0] S_RM_WR    = 5'd5;
    localparam logic [4:0] S_INS_INIT = 5'd6;
    localparam logic [4:0] S_INS_RD   = 5'd7;
    localparam logic [4:0] S_INS_WR   = 5'd8;
    localparam logic [4:0] S_READ_EM  = 5'd9;
    localparam logic [4:0] S_BS_RD    = 5'd10;
    localparam logic [4:0] S_BS_CHK   = 5'd11;
    localparam logic [4:0] S_SORT_LD  = 5'd12;
    localparam logic [4:0] S_SORT_CMP = 5'd13;
    localparam logic [4:0] S_SORT_END = 5'd14;
    localparam logic [4:0] S_SORT_FIN = 5'd15;
    localparam logic [4:0] S_DUMP_RD  = 5'd16;
    localparam logic [4:0] S_DUMP_EM  = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.uop    = oss_pkg::UOP_NOP;
        cmd.code   = oss_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.uop    = oss_pkg::UOP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (stat.op)
                    oss_pkg::OP_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.uop  = oss_pkg::UOP_EMIT_CODE;
                            cmd.code = oss_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.uop = oss_pkg::UOP_APPEND;
                        end
                    end
                    oss_pkg::OP_REMOVE, oss_pkg::OP_INS_AFTER, oss_pkg::OP_INS_BEFORE,
                    oss_pkg::OP_FIND_ALL:
                    begin
                        state_next = S_SCAN_RD;
                    end
                    oss_pkg::OP_READ:
                    begin
                        if (stat.pin_ok)
                        begin
                            cmd.uop    = oss_pkg::UOP_READ_PIN;
                            state_next = S_READ_EM;
                        end
                        else
                        begin
                            cmd.uop  = oss_pkg::UOP_EMIT_CODE;
                            cmd.code = oss_pkg::ST_RANGE;
                        end
                    end
                    oss_pkg::OP_BSEARCH:
                    begin
                        cmd.uop    = oss_pkg::UOP_BS_INIT;
                        state_next = S_BS_RD;
                    end
                    oss_pkg::OP_SORT:
                    begin
                        if (stat.cnt_ge2)
                        begin
                            cmd.uop    = oss_pkg::UOP_SORT_INIT;
                            state_next = S_SORT_LD;
                        end
                        else
                        begin
                            cmd.uop = oss_pkg::UOP_EMIT_CODE;
                        end
                    end
                    oss_pkg::OP_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.uop  = oss_pkg::UOP_EMIT_CODE;
                            cmd.code = oss_pkg::ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_DUMP_RD;
                        end
                    end
                    default:
                    begin
                        cmd.uop = oss_pkg::UOP_EMIT_CODE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_IDLE;
                    if (stat.op == oss_pkg::OP_FIND_ALL && stat.pend)
                    begin
                        cmd.uop = oss_pkg::UOP_FA_END;
                    end
                    else
                    begin
                        cmd.uop  = oss_pkg::UOP_EMIT_CODE;
                        cmd.code = oss_pkg::ST_NOT_FOUND;
                    end
                end
                else
                begin
                    cmd.uop    = oss_pkg::UOP_SCAN_RD;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.uop    = oss_pkg::UOP_SCAN_CHK;
                state_next = S_SCAN_RD;
                if (stat.match && stat.op == oss_pkg::OP_REMOVE)
                begin
                    state_next = S_RM_RD;
                end
                else if (stat.match && stat.op != oss_pkg::OP_FIND_ALL)
                begin
                    state_next = S_INS_INIT;
                end
            end
            S_RM_RD:
            begin
                if (stat.scan_done)
                begin
                    cmd.uop    = oss_pkg::UOP_RM_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.uop    = oss_pkg::UOP_RM_RD;
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                cmd.uop    = oss_pkg::UOP_RM_WR;
                state_next = S_RM_RD;
            end
            S_INS_INIT:
            begin
                if (stat.full)
                begin
                    cmd.uop    = oss_pkg::UOP_EMIT_CODE;
                    cmd.code   = oss_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.uop    = oss_pkg::UOP_INS_INIT;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (stat.ins_more)
                begin
                    cmd.uop    = oss_pkg::UOP_INS_RD;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.uop    = oss_pkg::UOP_INS_DONE;
                    state_next = S_IDLE;
                end
            end
            S_INS_WR:
            begin
                cmd.uop    = oss_pkg::UOP_INS_WR;
                state_next = S_INS_RD;
            end
            S_READ_EM:
            begin
                cmd.uop    = oss_pkg::UOP_EMIT_READ;
                state_next = S_IDLE;
            end
            S_BS_RD:
            begin
                if (stat.bs_done)
                begin
                    cmd.uop    = oss_pkg::UOP_EMIT_CODE;
                    cmd.code   = oss_pkg::ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.uop    = oss_pkg::UOP_BS_RD;
                    state_next = S_BS_CHK;
                end
            end
            S_BS_CHK:
            begin
                cmd.uop    = oss_pkg::UOP_BS_CHK;
                state_next = stat.match ? S_IDLE : S_BS_RD;
            end
            S_SORT_LD:
            begin
                cmd.uop    = oss_pkg::UOP_SORT_LD;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.uop = oss_pkg::UOP_SORT_CMP;
                if (stat.sort_last)
                begin
                    state_next = S_SORT_END;
                end
            end
            S_SORT_END:
            begin
                cmd.uop    = oss_pkg::UOP_SORT_END;
                state_next = stat.lim_one ? S_SORT_FIN : S_SORT_LD;
            end
            S_SORT_FIN:
            begin
                cmd.uop    = oss_pkg::UOP_EMIT_CODE;
                state_next = S_IDLE;
            end
            S_DUMP_RD:
            begin
                cmd.uop    = oss_pkg::UOP_DUMP_RD;
                state_next = S_DUMP_EM;
            end
            S_DUMP_EM:
            begin
                cmd.uop    = oss_pkg::UOP_DUMP_EMIT;
                state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### design/oss_datapath.sv
`default_nettype none
module oss_datapath #(
    parameter int CAPACITY = oss_pkg::DEFAULT_CAPACITY
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire oss_pkg::cmd_t      cmd,
    output oss_pkg::stat_t          stat,
    input  wire logic [3:0]         operation,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] new_value,
    input  wire logic [4:0]         position_in,
    output logic                    valid,
    output logic signed [31:0]      element,
    output logic [4:0]              position,
    output logic                    found,
    output logic [1:0]              status,
    output logic [5:0]              count,
    output logic                    last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data;

    logic [3:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] nv_reg, nv_next;
    logic [4:0]         pin_reg, pin_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   mpos_reg, mpos_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   lim_reg, lim_next;
    logic signed [31:0] cur_reg, cur_next;
    logic               pend_reg, pend_next;

    logic               valid_reg;
    logic signed [31:0] el_reg;
    logic [4:0]         pos_reg;
    logic               found_reg;
    logic [1:0]         st_reg;
    logic [5:0]         cnt_out_reg;
    logic               last_reg;

    logic               emit;
    logic signed [31:0] e_el;
    logic [CNT_W-1:0]   e_pos;
    logic               e_found;
    logic [1:0]         e_st;
    logic               e_last;

    logic               we, re;
    logic [IDX_W-1:0]   wa, ra;
    logic signed [31:0] wd;

    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   ins_tgt;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid;
    logic [31:0]        pin_w;
    logic [31:0]        pos_w;
    logic [31:0]        cnt_w;
    logic               swap;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign ins_tgt = mpos_reg + CNT_W'(op_reg == oss_pkg::OP_INS_AFTER);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, lim_reg} - (CNT_W + 1)'(1);
    assign mid     = mid_sum[CNT_W:1];
    assign pin_w   = 32'(pin_reg);
    assign swap    = cur_reg > rd_data;

    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = (cnt_reg == CNT_W'(CAPACITY));
        stat.empty     = (cnt_reg == '0);
        stat.cnt_ge2   = (cnt_reg >= CNT_W'(2));
        stat.pin_ok    = (pin_w < 32'(cnt_reg));
        stat.scan_done = (idx_reg >= cnt_reg);
        stat.match     = (rd_data == key_reg);
        stat.pend      = pend_reg;
        stat.ins_more  = (idx_reg > ins_tgt);
        stat.bs_done   = (lo_reg >= lim_reg);
        stat.sort_last = (idx_inc == lim_reg);
        stat.lim_one   = (lim_reg == CNT_W'(1));
        stat.dump_last = (idx_inc == cnt_reg);
    end

    always_comb
    begin
        op_next   = op_reg;
        key_next  = key_reg;
        nv_next   = nv_reg;
        pin_next  = pin_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        mpos_next = mpos_reg;
        lo_next   = lo_reg;
        lim_next  = lim_reg;
        cur_next  = cur_reg;
        pend_next = pend_reg;
        emit      = 1'b0;
        e_el      = '0;
        e_pos     = '0;
        e_found   = 1'b0;
        e_st      = oss_pkg::ST_OK;
        e_last    = 1'b1;
        we        = 1'b0;
        re        = 1'b0;
        wa        = '0;
        ra        = '0;
        wd        = '0;
        case (cmd.uop)
            oss_pkg::UOP_LOAD:
            begin
                op_next   = operation;
                key_next  = key;
                nv_next   = new_value;
                pin_next  = position_in;
                idx_next  = '0;
                pend_next = 1'b0;
            end
            oss_pkg::UOP_EMIT_CODE:
            begin
                emit = 1'b1;
                e_st = cmd.code;
            end
            oss_pkg::UOP_APPEND:
            begin
                we       = 1'b1;
                wa       = cnt_reg[IDX_W-1:0];
                wd       = nv_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                emit     = 1'b1;
                e_pos    = cnt_reg;
            end
            oss_pkg::UOP_SCAN_RD, oss_pkg::UOP_RM_RD, oss_pkg::UOP_DUMP_RD:
            begin
                re = 1'b1;
                ra = idx_reg[IDX_W-1:0];
            end
            oss_pkg::UOP_SCAN_CHK:
            begin
                idx_next = idx_inc;
                if (rd_data == key_reg)
                begin
                    mpos_next = idx_reg;
                    pend_next = 1'b1;
                    // previous match is now known not to be the final one
                    if (op_reg == oss_pkg::OP_FIND_ALL && pend_reg)
                    begin
                        emit    = 1'b1;
                        e_el    = key_reg;
                        e_pos   = mpos_reg;
                        e_found = 1'b1;
                        e_last  = 1'b0;
                    end
                end
            end
            oss_pkg::UOP_FA_END:
            begin
                emit    = 1'b1;
                e_el    = key_reg;
                e_pos   = mpos_reg;
                e_found = 1'b1;
            end
            oss_pkg::UOP_RM_WR:
            begin
                we       = 1'b1;
                wa       = IDX_W'(idx_reg - CNT_W'(1));
                wd       = rd_data;
                idx_next = idx_inc;
            end
            oss_pkg::UOP_RM_DONE:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                emit     = 1'b1;
                e_el     = key_reg;
                e_pos    = mpos_reg;
                e_found  = 1'b1;
            end
            oss_pkg::UOP_INS_INIT:
            begin
                idx_next = cnt_reg;
            end
            oss_pkg::UOP_INS_RD:
            begin
                re = 1'b1;
                ra = IDX_W'(idx_reg - CNT_W'(1));
            end
            oss_pkg::UOP_INS_WR:
            begin
                we       = 1'b1;
                wa       = idx_reg[IDX_W-1:0];
                wd       = rd_data;
                idx_next = idx_reg - CNT_W'(1);
            end
            oss_pkg::UOP_INS_DONE:
            begin
                we       = 1'b1;
                wa       = ins_tgt[IDX_W-1:0];
                wd       = nv_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                emit     = 1'b1;
                e_pos    = ins_tgt;
            end
            oss_pkg::UOP_READ_PIN:
            begin
                re = 1'b1;
                ra = pin_w[IDX_W-1:0];
            end
            oss_pkg::UOP_EMIT_READ:
            begin
                emit    = 1'b1;
                e_el    = rd_data;
                e_pos   = CNT_W'(pin_w);
                e_found = 1'b1;
            end
            oss_pkg::UOP_BS_INIT:
            begin
                lo_next  = '0;
                lim_next = cnt_reg;
            end
            oss_pkg::UOP_BS_RD:
            begin
                re = 1'b1;
                ra = mid[IDX_W-1:0];
            end
            oss_pkg::UOP_BS_CHK:
            begin
                if (rd_data == key_reg)
                begin
                    emit    = 1'b1;
                    e_el    = key_reg;
                    e_pos   = mid;
                    e_found = 1'b1;
                end
                else if (rd_data < key_reg)
                begin
                    lo_next = mid + CNT_W'(1);
                end
                else
                begin
                    lim_next = mid;
                end
            end
            oss_pkg::UOP_SORT_INIT:
            begin
                idx_next = '0;
                lim_next = cnt_reg - CNT_W'(1);
                re       = 1'b1;
            end
            oss_pkg::UOP_SORT_LD:
            begin
                cur_next = rd_data;
                re       = 1'b1;
                ra       = idx_inc[IDX_W-1:0];
            end
            oss_pkg::UOP_SORT_CMP:
            begin
                // smaller value settles here, larger one travels on
                we       = 1'b1;
                wa       = idx_reg[IDX_W-1:0];
                wd       = swap ? rd_data : cur_reg;
                cur_next = swap ? cur_reg : rd_data;
                idx_next = idx_inc;
                if (idx_inc != lim_reg)
                begin
                    re = 1'b1;
                    ra = IDX_W'(idx_reg + CNT_W'(2));
                end
            end
            oss_pkg::UOP_SORT_END:
            begin
                we       = 1'b1;
                wa       = lim_reg[IDX_W-1:0];
                wd       = cur_reg;
                lim_next = lim_reg - CNT_W'(1);
                idx_next = '0;
                re       = 1'b1;
            end
            oss_pkg::UOP_DUMP_EMIT:
            begin
                emit     = 1'b1;
                e_el     = rd_data;
                e_pos    = idx_reg;
                e_found  = 1'b1;
                e_last   = (idx_inc == cnt_reg);
                idx_next = idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    assign pos_w = 32'(e_pos);
    assign cnt_w = 32'(cnt_next);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= emit;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        nv_reg   <= nv_next;
        pin_reg  <= pin_next;
        idx_reg  <= idx_next;
        mpos_reg <= mpos_next;
        lo_reg   <= lo_next;
        lim_reg  <= lim_next;
        cur_reg  <= cur_next;
        if (emit)
        begin
            el_reg      <= e_el;
            pos_reg     <= pos_w[4:0];
            found_reg   <= e_found;
            st_reg      <= e_st;
            cnt_out_reg <= cnt_w[5:0];
            last_reg    <= e_last;
        end
    end

    assign valid    = valid_reg;
    assign element  = el_reg;
    assign position = pos_reg;
    assign found    = found_reg;
    assign status   = st_reg;
    assign count    = cnt_out_reg;
    assign last     = last_reg;

endmodule
`default_nettype wire

### design/ordered_sequence_store.sv
`default_nettype none
// Channel   Direction  Handshake                  Payload
// request   in         start, busy                operation, key, new_value, position_in
// result    out        valid (one-cycle strobe)   element, position, found, status,
//                                                 count, last
//
// A request is taken when start is high and busy is low; busy drops in the cycle
// that the last result is on the ports. Remove, insert, find all and dump walk the
// stored elements one at a time, binary search halves its range step by step, and sort
// makes repeated passes over the elements, all through the element memory with one
// write port and one registered read port.
// rst_n clears the count and the controller; the receiver cannot stall results.
`include "ordered_sequence_store_defines.svh"
module ordered_sequence_store #(
    parameter int CAPACITY = oss_pkg::DEFAULT_CAPACITY
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         operation,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] new_value,
    input  wire logic [4:0]         position_in,
    output logic                    valid,
    output logic signed [31:0]      element,
    output logic [4:0]              position,
    output logic                    found,
    output logic [1:0]              status,
    output logic [5:0]              count,
    output logic                    last
);

    oss_pkg::cmd_t  cmd;
    oss_pkg::stat_t stat;

    oss_control u_control (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    oss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .key         (key),
        .new_value   (new_value),
        .position_in (position_in),
        .valid       (valid),
        .element     (element),
        .position    (position),
        .found       (found),
        .status      (status),
        .count       (count),
        .last        (last)
    );

    `OSS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `OSS_ASSERT(a_more_busy, clk, rst_n, valid && !last |-> busy)
    `OSS_ASSERT(a_found_ok, clk, rst_n, valid && found |-> status == oss_pkg::ST_OK)
    `OSS_ASSERT(a_err_last, clk, rst_n, valid && status != oss_pkg::ST_OK |-> last)

endmodule
`default_nettype wire

### sim/tb_ordered_sequence_store.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_ordered_sequence_store;
    import oss_pkg::*;

    localparam int CAP = 32;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] element;
        logic [4:0]         position;
        logic               found;
        logic [1:0]         status;
        logic [5:0]         count;
        logic               last;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
    logic [4:0]         position_in;
    logic               valid;
    logic signed [31:0] element;
    logic [4:0]         position;
    logic               found;
    logic [1:0]         status;
    logic [5:0]         count;
    logic               last;

    logic signed [31:0] shadow_list [CAP];
    int                 shadow_count;
    outcome_t           pending_outcomes [$];
    int                 error_total;
    int                 idle_cycles;
    int                 burst_left;

    ordered_sequence_store u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .key(key), .new_value(new_value),
        .position_in(position_in), .valid(valid), .element(element),
        .position(position), .found(found), .status(status),
        .count(count), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic outcome_t mk(logic signed [31:0] el, int pos, logic fnd,
                                    logic [1:0] st, logic lst);
        outcome_t r;
        r.element = el;
        r.position = pos[4:0];
        r.found = fnd;
        r.status = st;
        r.count = shadow_count[5:0];
        r.last = lst;
        return r;
    endfunction

    function automatic int first_index(logic signed [31:0] k);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_list[i] == k)
                return i;
        return -1;
    endfunction

    // Apply one request to the shadow list and queue the outcomes it produces.
    function automatic void predict_request(logic [3:0] op, logic signed [31:0] k,
                                            logic signed [31:0] nv, logic [4:0] pin);
        int m;
        int n;
        int lo;
        int hi;
        int mid;
        int idx;
        logic signed [31:0] t;
        n = 0;
        case (op)
            OP_APPEND:
                if (shadow_count >= CAP)
                    pending_outcomes.push_back(mk(0, 0, 0, ST_FULL, 1));
                else
                begin
                    shadow_list[shadow_count] = nv;
                    shadow_count++;
                    pending_outcomes.push_back(mk(0, shadow_count - 1, 0, ST_OK, 1));
                end
            OP_REMOVE:
            begin
                m = first_index(k);
                if (m < 0)
                    pending_outcomes.push_back(mk(0, 0, 0, ST_NOT_FOUND, 1));
                else
                begin
                    for (int i = m; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                    pending_outcomes.push_back(mk(k, m, 1, ST_OK, 1));
                end
            end
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                m = first_index(k);
                if (m < 0)
                    pending_outcomes.push_back(mk(0, 0, 0, ST_NOT_FOUND, 1));
                else if (shadow_count >= CAP)
                    pending_outcomes.push_back(mk(0, 0, 0, ST_FULL, 1));
                else
                begin
                    idx = m + ((op == OP_INS_AFTER) ? 1 : 0);
                    for (int i = shadow_count; i > idx; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[idx] = nv;
                    shadow_count++;
                    pending_outcomes.push_back(mk(0, idx, 0, ST_OK, 1));
                end
            end
            OP_READ:
                if (pin < shadow_count)
                    pending_outcomes.push_back(mk(shadow_list[pin], pin, 1, ST_OK, 1));
                else
                    pending_outcomes.push_back(mk(0, 0, 0, ST_RANGE, 1));
            OP_FIND_ALL:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_list[i] == k)
                    begin
                        pending_outcomes.push_back(mk(k, i, 1, ST_OK, 0));
                        n++;
                    end
                if (n == 0)
                    pending_outcomes.push_back(mk(0, 0, 0, ST_NOT_FOUND, 1));
                else
                    pending_outcomes[$].last = 1'b1;
            end
            OP_BSEARCH:
            begin
                lo = 0;
                hi = shadow_count - 1;
                m = -1;
                while (lo <= hi && m < 0)
                begin
                    mid = (lo + hi) / 2;
                    if (shadow_list[mid] == k)
                        m = mid;
                    else if (shadow_list[mid] < k)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                if (m < 0)
                    pending_outcomes.push_back(mk(0, 0, 0, ST_NOT_FOUND, 1));
                else
                    pending_outcomes.push_back(mk(k, m, 1, ST_OK, 1));
            end
            OP_SORT:
            begin
                for (int i = 0; i + 1 < shadow_count; i++)
                    for (int j = 0; j + 1 < shadow_count - i; j++)
                        if (shadow_list[j] > shadow_list[j + 1])
                        begin
                            t = shadow_list[j];
                            shadow_list[j] = shadow_list[j + 1];
                            shadow_list[j + 1] = t;
                        end
                pending_outcomes.push_back(mk(0, 0, 0, ST_OK, 1));
            end
            OP_DUMP:
                if (shadow_count == 0)
                    pending_outcomes.push_back(mk(0, 0, 0, ST_RANGE, 1));
                else
                    for (int i = 0; i < shadow_count; i++)
                        pending_outcomes.push_back(mk(shadow_list[i], i, 1, ST_OK,
                                                      i + 1 == shadow_count));
            default:
                pending_outcomes.push_back(mk(0, 0, 0, ST_OK, 1));
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge with start still high,
    // so the next request or a drain decides what start does there.
    task automatic send_request(logic [3:0] op, logic signed [31:0] k,
                                logic signed [31:0] nv, logic [4:0] pin);
        // Bursts with random gaps between them.
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        operation <= op;
        key <= k;
        new_value <= nv;
        position_in <= pin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(op, k, nv, pin);
        @(negedge clk);
    endtask

    task automatic drain_outcomes();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom();
            default: return $signed($urandom_range(0, 12)) - 6;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            return shadow_list[$urandom_range(0, shadow_count - 1)];
        return pick_value();
    endfunction

    task automatic test_empty_store();
        send_request(OP_DUMP, 0, 0, 0);
        send_request(OP_READ, 0, 0, 0);
        send_request(OP_FIND_ALL, 5, 0, 0);
        send_request(OP_BSEARCH, 5, 0, 0);
        send_request(OP_SORT, 0, 0, 0);
        send_request(OP_REMOVE, 5, 0, 0);
        send_request(OP_INS_AFTER, 5, 1, 0);
        send_request(4'd15, 32'shffff_ffff, 32'shffff_ffff, 5'd31);
    endtask

    task automatic test_single_element();
        send_request(OP_APPEND, 0, 32'sh7fff_ffff, 0);
        send_request(OP_INS_BEFORE, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_request(OP_INS_AFTER, 32'sh8000_0000, 7, 0);
        send_request(OP_FIND_ALL, 32'sh8000_0000, 0, 0);
        send_request(OP_SORT, 0, 0, 0);
        send_request(OP_BSEARCH, 32'sh7fff_ffff, 0, 0);
        send_request(OP_READ, 0, 0, 5'd2);
        send_request(OP_READ, 0, 0, 5'd3);
        send_request(OP_REMOVE, 7, 0, 0);
        send_request(OP_REMOVE, 32'sh7fff_ffff, 0, 0);
        send_request(OP_REMOVE, 32'sh8000_0000, 0, 0);
        send_request(OP_APPEND, 0, 3, 0);
        send_request(OP_REMOVE, 3, 0, 0);
        drain_outcomes();
    endtask

    task automatic test_full_store();
        while (shadow_count < CAP)
            send_request(OP_APPEND, 0, $signed($urandom_range(0, 3)), 0);
        send_request(OP_APPEND, 0, 9, 0);
        send_request(OP_INS_AFTER, 1, 9, 0);
        send_request(OP_INS_BEFORE, 99, 9, 0);
        send_request(OP_READ, 0, 0, 5'd31);
        send_request(OP_FIND_ALL, 2, 0, 0);
        send_request(OP_SORT, 0, 0, 0);
        send_request(OP_DUMP, 0, 0, 0);
        while (shadow_count > 0)
            send_request(OP_REMOVE, shadow_list[$urandom_range(0, shadow_count - 1)], 0, 0);
    endtask

    task automatic test_random_ops();
        logic [3:0] op;
        for (int n = 0; n < 110; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                drain_outcomes();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: op = OP_APPEND;
                5, 6: op = OP_REMOVE;
                7, 8: op = OP_INS_AFTER;
                9, 10: op = OP_INS_BEFORE;
                11, 12: op = OP_READ;
                13: op = OP_FIND_ALL;
                14, 15: op = OP_BSEARCH;
                16: op = OP_SORT;
                17: op = OP_DUMP;
                18: op = 4'($urandom_range(9, 15));
                default: op = 4'($urandom_range(0, 15));
            endcase
            send_request(op, pick_key(), pick_value(), 5'($urandom()));
        end
    endtask

    // Compare each strobed outcome against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected outcome element=%0d position=%0d", $time,
                         element, position);
                error_total++;
            end
            else
            begin
                if (element !== pending_outcomes[0].element ||
                    position !== pending_outcomes[0].position ||
                    found !== pending_outcomes[0].found ||
                    status !== pending_outcomes[0].status ||
                    count !== pending_outcomes[0].count ||
                    last !== pending_outcomes[0].last)
                begin
                    $display("%0t: expected el=%0d pos=%0d fnd=%0b st=%0d cnt=%0d last=%0b",
                             $time, pending_outcomes[0].element,
                             pending_outcomes[0].position, pending_outcomes[0].found,
                             pending_outcomes[0].status, pending_outcomes[0].count,
                             pending_outcomes[0].last);
                    $display("%0t: actual   el=%0d pos=%0d fnd=%0b st=%0d cnt=%0d last=%0b",
                             $time, element, position, found, status, count, last);
                    error_total++;
                end
                void'(pending_outcomes.pop_front());
            end
        end
    end

    // Watchdog: count cycles in which no request is accepted and no result is strobed.
    always @(posedge clk)
    begin
        if (!rst_n || valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        key = '0;
        new_value = '0;
        position_in = '0;
        shadow_count = 0;
        error_total = 0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_store();
        test_single_element();
        test_full_store();
        test_random_ops();
        drain_outcomes();
        repeat (20) @(negedge clk);
        if (error_total == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

### ordered_sequence_store.f
+incdir+design
design/oss_pkg.sv
design/oss_control.sv
design/oss_datapath.sv
design/ordered_sequence_store.sv
sim/tb_ordered_sequence_store.sv
